// File: src/mea_pkg.sv
// Shared types, request codes and saturation helpers for the multipole expansion accumulator.
// No dependencies.
`default_nettype none

package mea_pkg;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [7:0] CFG_ORDER = 8'd0;
    localparam logic [7:0] CFG_LEVEL = 8'd1;

    localparam logic [5:0] ORDER_RESET = 6'd16;
    localparam logic [4:0] LEVEL_RESET = 5'd0;

    typedef struct packed {
        logic        [1:0]  req_type;
        logic signed [31:0] offset_re;
        logic signed [31:0] offset_im;
        logic signed [31:0] charge;
        logic signed [31:0] dipole_x;
        logic signed [31:0] dipole_y;
        logic               has_dipole;
    } t_req;

    typedef struct packed {
        logic        [5:0]  coeff_order;
        logic signed [47:0] coeff_re;
        logic signed [47:0] coeff_im;
        logic               last;
        logic               saturated;
    } t_result;

    typedef struct packed {
        logic [5:0] expansion_order;
        logic [4:0] box_level;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic               sh31;
        logic signed [47:0] a;
        logic signed [47:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [47:0] res;
    } t_mul_rsp;

    // {sat, value}: clamp a magnitude to the signed 48-bit range
    function automatic logic [48:0] clamp48(input logic [79:0] mag, input logic neg);
        logic [79:0] lim;
        logic        sat;
        logic [47:0] m;
        lim = neg ? 80'h800000000000 : 80'h7FFFFFFFFFFF;
        sat = mag > lim;
        m   = sat ? lim[47:0] : mag[47:0];
        return {sat, (neg ? (~m + 48'd1) : m)};
    endfunction

    // {sat, value}: saturate a signed sum to 48 bits
    function automatic logic [48:0] sat48(input logic signed [49:0] v);
        if (v > 50'sh7FFFFFFFFFFF) begin
            return {1'b1, 48'h7FFFFFFFFFFF};
        end else if (v < -50'sh800000000000) begin
            return {1'b1, 48'h800000000000};
        end
        return {1'b0, v[47:0]};
    endfunction

endpackage

`default_nettype wire

// File: src/multipole_expansion_accumulator_top.sv
// Top level of the 2D Laplace multipole expansion accumulator: config registers,
// front queue, sequencer and shared multiplier. Depends on mea_pkg, mea_front, mea_mul, mea_back.
//
// Requests enter on start when busy is low; up to two wait in the front queue while the
// sequencer works. A readout delivers p+1 coefficients on consecutive cycles, one per
// strobe; the receiver cannot stall them. An add is paced by the shared multiplier: every
// product passes issue, four 24x24 partial products, round and hand-back, and each order
// above 1 needs 7 products (11 with dipole) plus a read-modify-write (read state, then
// write state) per accumulation; order 1 needs only 3 products.
`default_nettype none

module multipole_expansion_accumulator_top #(
    parameter int MAX_ORDER = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  mea_pkg::t_req     i_req,
    output logic              busy,
    output logic              o_result_strobe,
    output mea_pkg::t_result  o_result,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  [7:0]        i_cfg_index,
    input  wire  [31:0]       i_cfg_data
);
    import mea_pkg::*;

    logic [5:0] r_order;
    logic [4:0] r_level;
    t_cfg       cfg;
    logic       item_valid, back_ready;
    t_req       item;
    t_mul_req   mul_req;
    t_mul_rsp   mul_rsp;

    assign o_cfg_ready = 1'b1;
    assign cfg = '{expansion_order: r_order, box_level: r_level};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
            r_level <= LEVEL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORDER: r_order <= i_cfg_data[5:0];
                CFG_LEVEL: r_level <= i_cfg_data[4:0];
                default:   r_order <= r_order;
            endcase
        end
    end

    mea_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req        (i_req),
        .busy         (busy),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_back_ready (back_ready)
    );

    mea_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    mea_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_item_valid    (item_valid),
        .i_item          (item),
        .o_ready         (back_ready),
        .o_mul_req       (mul_req),
        .i_mul_rsp       (mul_rsp),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

`default_nettype wire

// File: src/mea_front.sv
// Front end: takes requests, drops unused request codes, holds them in a two-entry queue.
// Depends on mea_pkg.
`default_nettype none

module mea_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    input  mea_pkg::t_req  i_req,
    output logic           busy,
    output logic           o_item_valid,
    output mea_pkg::t_req  o_item,
    input  wire            i_back_ready
);
    import mea_pkg::*;

    t_req       r_q [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign busy         = (r_cnt == 2'd2);
    assign push         = start && !busy && (i_req.req_type != 2'd3);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign pop          = o_item_valid && i_back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req;
        end
    end

endmodule

`default_nettype wire

// File: src/mea_mul.sv
// Shared rounding multiplier: 48x48 signed magnitudes from four 24x24 partial products.
// Depends on mea_pkg.
`default_nettype none

module mea_mul (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  mea_pkg::t_mul_req  i_req,
    output mea_pkg::t_mul_rsp  o_rsp
);
    import mea_pkg::*;

    logic        r_run, r_fin, r_done, r_neg, r_sh31, r_sat;
    logic [1:0]  r_cnt;
    logic [95:0] r_acc;
    logic [47:0] r_ma, r_mb;
    logic signed [47:0] r_res;
    logic [23:0] ai, bi;
    logic [47:0] pp;
    logic [95:0] pp_sh;
    logic [96:0] rsum;
    logic [96:0] rshift;
    logic [48:0] cl;

    always_comb begin
        ai    = r_cnt[1] ? r_ma[47:24] : r_ma[23:0];
        bi    = r_cnt[0] ? r_mb[47:24] : r_mb[23:0];
        pp    = ai * bi;
        pp_sh = {48'd0, pp} << (7'd24 * ({6'd0, r_cnt[1]} + {6'd0, r_cnt[0]}));
        rsum  = {1'b0, r_acc} + (r_sh31 ? 97'h40000000 : 97'h800000);
        rshift = r_sh31 ? (rsum >> 31) : (rsum >> 24);
        cl    = clamp48(rshift[79:0], r_neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_cnt  <= 2'd0;
                r_acc  <= '0;
                r_ma   <= i_req.a[47] ? (~i_req.a + 48'd1) : i_req.a;
                r_mb   <= i_req.b[47] ? (~i_req.b + 48'd1) : i_req.b;
                r_neg  <= i_req.a[47] ^ i_req.b[47];
                r_sh31 <= i_req.sh31;
            end else if (r_run) begin
                r_acc <= r_acc + pp_sh;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_sat  <= cl[48];
                r_res  <= cl[47:0];
            end
        end
    end

    assign o_rsp = '{done: r_done, sat: r_sat, res: r_res};

endmodule

`default_nettype wire

// File: src/mea_back.sv
// Back end: sequencer for clear, particle add and readout, with the coefficient memory.
// Depends on mea_pkg; drives the shared multiplier mea_mul.
`default_nettype none

module mea_back #(
    parameter int MAX_ORDER = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  mea_pkg::t_cfg      i_cfg,
    input  wire                i_item_valid,
    input  mea_pkg::t_req      i_item,
    output logic               o_ready,
    output mea_pkg::t_mul_req  o_mul_req,
    input  mea_pkg::t_mul_rsp  i_mul_rsp,
    output logic               o_result_strobe,
    output mea_pkg::t_result   o_result
);
    import mea_pkg::*;

    localparam int JW = $clog2(MAX_ORDER + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SETUP    = 7'b0000010,
        S_MUL_GO   = 7'b0000100,
        S_MUL_WAIT = 7'b0001000,
        S_ACC_RD   = 7'b0010000,
        S_ACC_WR   = 7'b0100000,
        S_READ     = 7'b1000000
    } t_state;

    typedef enum logic [10:0] {
        K_P1 = 11'b00000000001,
        K_P2 = 11'b00000000010,
        K_P3 = 11'b00000000100,
        K_P4 = 11'b00000001000,
        K_H  = 11'b00000010000,
        K_TR = 11'b00000100000,
        K_TI = 11'b00001000000,
        K_D1 = 11'b00010000000,
        K_D2 = 11'b00100000000,
        K_D3 = 11'b01000000000,
        K_D4 = 11'b10000000000
    } t_step;

    t_state r_state;
    t_step  r_k;
    logic [JW-1:0] r_j, r_p;
    t_req   r_item;
    logic signed [47:0] r_zr, r_zi, r_mx, r_my, r_qq;
    logic signed [47:0] r_mr, r_mi, r_pr, r_pi, r_h;
    logic signed [47:0] r_ta, r_tb, r_tc;
    logic signed [48:0] r_dre, r_dim;
    logic r_chain, r_s, r_flag, r_kind, r_dip;

    logic [95:0] r_mem [0:MAX_ORDER];
    logic [95:0] r_mem_q;
    logic [MAX_ORDER:0] r_vld, r_mark;

    logic          r_out_pend, r_out_last, r_out_vld, r_out_mark;
    logic [JW-1:0] r_out_j;

    logic [31:0] w_rom [0:MAX_ORDER];
    logic [JW-1:0] p_clamp;
    logic [31:0] mag_re, mag_im, mag_dx, mag_dy;
    logic [5:0]  dsh;
    logic [48:0] c_zr, c_zi, c_mx, c_my;
    logic [48:0] sr, si, ar, ai;
    logic signed [47:0] cur_re, cur_im;
    logic signed [47:0] mul_a, mul_b;

    assign w_rom[0] = '0;
    for (genvar g = 1; g <= MAX_ORDER; g++) begin : g_rom
        localparam logic [63:0] RQ = (64'd1 << 32) / g;
        localparam logic [31:0] RV = 32'((RQ + 64'd1) >> 1);
        assign w_rom[g] = RV;
    end

    always_comb begin
        if (i_cfg.expansion_order == 6'd0) begin
            p_clamp = JW'(1);
        end else if (int'(i_cfg.expansion_order) > MAX_ORDER) begin
            p_clamp = JW'(MAX_ORDER);
        end else begin
            p_clamp = JW'(i_cfg.expansion_order);
        end
    end

    always_comb begin
        mag_re = r_item.offset_re[31] ? (~r_item.offset_re + 32'd1) : r_item.offset_re;
        mag_im = r_item.offset_im[31] ? (~r_item.offset_im + 32'd1) : r_item.offset_im;
        mag_dx = r_item.dipole_x[31] ? (~r_item.dipole_x + 32'd1) : r_item.dipole_x;
        mag_dy = r_item.dipole_y[31] ? (~r_item.dipole_y + 32'd1) : r_item.dipole_y;
        dsh    = {1'b0, i_cfg.box_level} + 6'd8;
        c_zr = clamp48(((80'(mag_re) << i_cfg.box_level) + 80'd32) >> 6, r_item.offset_re[31]);
        c_zi = clamp48(((80'(mag_im) << i_cfg.box_level) + 80'd32) >> 6, r_item.offset_im[31]);
        c_mx = clamp48(80'(mag_dx) << dsh, r_item.dipole_x[31]);
        c_my = clamp48(80'(mag_dy) << dsh, r_item.dipole_y[31]);
    end

    always_comb begin
        sr = sat48({{2{r_ta[47]}}, r_ta} - {{2{r_tb[47]}}, r_tb});
        si = sat48({{2{r_tc[47]}}, r_tc} + {{2{i_mul_rsp.res[47]}}, i_mul_rsp.res});
        cur_re = r_vld[r_j] ? r_mem_q[95:48] : '0;
        cur_im = r_vld[r_j] ? r_mem_q[47:0] : '0;
        ar = sat48({{2{cur_re[47]}}, cur_re} + {r_dre[48], r_dre});
        ai = sat48({{2{cur_im[47]}}, cur_im} + {r_dim[48], r_dim});
    end

    always_comb begin
        mul_a = r_mr;
        mul_b = r_zr;
        case (r_k)
            K_P1:    begin mul_a = r_mr; mul_b = r_zr; end
            K_P2:    begin mul_a = r_pi; mul_b = r_zi; end
            K_P3:    begin mul_a = r_pr; mul_b = r_zi; end
            K_P4:    begin mul_a = r_pi; mul_b = r_zr; end
            K_H:     begin mul_a = r_qq; mul_b = {16'd0, w_rom[r_j]}; end
            K_TR:    begin mul_a = r_h;  mul_b = r_mr; end
            K_TI:    begin mul_a = r_h;  mul_b = r_mi; end
            K_D1:    begin mul_a = r_mx; mul_b = r_pr; end
            K_D2:    begin mul_a = r_my; mul_b = r_pi; end
            K_D3:    begin mul_a = r_mx; mul_b = r_pi; end
            K_D4:    begin mul_a = r_my; mul_b = r_pr; end
            default: begin mul_a = r_mr; mul_b = r_zr; end
        endcase
    end

    assign o_mul_req = '{start: (r_state == S_MUL_GO), sh31: (r_k == K_H), a: mul_a, b: mul_b};
    assign o_ready   = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_k        <= K_P1;
            r_j        <= '0;
            r_p        <= JW'(1);
            r_vld      <= '0;
            r_mark     <= '0;
            r_out_pend <= 1'b0;
        end else begin
            r_out_pend <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item <= i_item;
                        r_p    <= p_clamp;
                        r_j    <= '0;
                        case (i_item.req_type)
                            REQ_CLEAR: begin
                                r_vld  <= '0;
                                r_mark <= '0;
                            end
                            REQ_ADD:  r_state <= S_SETUP;
                            REQ_READ: r_state <= S_READ;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_zr    <= c_zr[47:0];
                    r_zi    <= c_zi[47:0];
                    r_mr    <= c_zr[47:0];
                    r_mi    <= c_zi[47:0];
                    r_mx    <= c_mx[47:0];
                    r_my    <= c_my[47:0];
                    r_dip   <= r_item.has_dipole;
                    r_qq    <= {{8{r_item.charge[31]}}, r_item.charge, 8'd0};
                    r_chain <= c_zr[48] | c_zi[48] | (r_item.has_dipole & (c_mx[48] | c_my[48]));
                    r_flag  <= c_zr[48] | c_zi[48] | (r_item.has_dipole & (c_mx[48] | c_my[48]));
                    r_dre   <= -{{9{r_item.charge[31]}}, r_item.charge, 8'd0};
                    r_dim   <= '0;
                    r_kind  <= 1'b0;
                    r_state <= S_ACC_RD;
                end
                S_MUL_GO: begin
                    if (r_k == K_P1) begin
                        r_pr <= r_mr;
                        r_pi <= r_mi;
                    end
                    r_state <= S_MUL_WAIT;
                end
                S_MUL_WAIT: begin
                    if (i_mul_rsp.done) begin
                        r_state <= S_MUL_GO;
                        case (r_k)
                            K_P1: begin
                                r_ta <= i_mul_rsp.res; r_chain <= r_chain | i_mul_rsp.sat;
                                r_k <= K_P2;
                            end
                            K_P2: begin
                                r_tb <= i_mul_rsp.res; r_chain <= r_chain | i_mul_rsp.sat;
                                r_k <= K_P3;
                            end
                            K_P3: begin
                                r_tc <= i_mul_rsp.res; r_chain <= r_chain | i_mul_rsp.sat;
                                r_k <= K_P4;
                            end
                            K_P4: begin
                                r_mr    <= sr[47:0];
                                r_mi    <= si[47:0];
                                r_chain <= r_chain | i_mul_rsp.sat | sr[48] | si[48];
                                r_k     <= K_H;
                            end
                            K_H: begin
                                r_h <= i_mul_rsp.res; r_s <= i_mul_rsp.sat; r_k <= K_TR;
                            end
                            K_TR: begin
                                r_ta <= i_mul_rsp.res; r_s <= r_s | i_mul_rsp.sat; r_k <= K_TI;
                            end
                            K_TI: begin
                                r_dre   <= -{r_ta[47], r_ta};
                                r_dim   <= -{i_mul_rsp.res[47], i_mul_rsp.res};
                                r_flag  <= r_chain | r_s | i_mul_rsp.sat;
                                r_kind  <= 1'b0;
                                r_state <= S_ACC_RD;
                            end
                            K_D1: begin
                                r_ta <= i_mul_rsp.res; r_s <= i_mul_rsp.sat; r_k <= K_D2;
                            end
                            K_D2: begin
                                r_tb <= i_mul_rsp.res; r_s <= r_s | i_mul_rsp.sat; r_k <= K_D3;
                            end
                            K_D3: begin
                                r_tc <= i_mul_rsp.res; r_s <= r_s | i_mul_rsp.sat; r_k <= K_D4;
                            end
                            K_D4: begin
                                r_dre   <= {sr[47], sr[47:0]};
                                r_dim   <= {si[47], si[47:0]};
                                r_flag  <= r_chain | r_s | i_mul_rsp.sat | sr[48] | si[48];
                                r_kind  <= 1'b1;
                                r_state <= S_ACC_RD;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ACC_RD: begin
                    r_state <= S_ACC_WR;
                end
                S_ACC_WR: begin
                    r_vld[r_j] <= 1'b1;
                    if (r_flag | ar[48] | ai[48]) begin
                        r_mark[r_j] <= 1'b1;
                    end
                    if (r_j == '0) begin
                        r_j     <= JW'(1);
                        r_k     <= K_H;
                        r_state <= S_MUL_GO;
                    end else if (!r_kind && r_dip) begin
                        if (r_j == JW'(1)) begin
                            r_dre   <= {r_mx[47], r_mx};
                            r_dim   <= {r_my[47], r_my};
                            r_flag  <= r_chain;
                            r_kind  <= 1'b1;
                            r_state <= S_ACC_RD;
                        end else begin
                            r_k     <= K_D1;
                            r_state <= S_MUL_GO;
                        end
                    end else if (r_j == r_p) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_j     <= r_j + JW'(1);
                        r_k     <= K_P1;
                        r_state <= S_MUL_GO;
                    end
                end
                S_READ: begin
                    r_out_pend <= 1'b1;
                    if (r_j == r_p) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem_q    <= r_mem[r_j];
        r_out_j    <= r_j;
        r_out_last <= (r_j == r_p);
        r_out_vld  <= r_vld[r_j];
        r_out_mark <= r_mark[r_j];
        if (r_state == S_ACC_WR) begin
            r_mem[r_j] <= {ar[47:0], ai[47:0]};
        end
    end

    assign o_result_strobe = r_out_pend;
    assign o_result = '{
        coeff_order: 6'(r_out_j),
        coeff_re:    r_out_vld ? r_mem_q[95:48] : 48'sd0,
        coeff_im:    r_out_vld ? r_mem_q[47:0] : 48'sd0,
        last:        r_out_last,
        saturated:   r_out_mark
    };

    a_strobe_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state == S_READ))
        else $error("result strobe without readout");

    a_done_while_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_rsp.done |-> (r_state == S_MUL_WAIT))
        else $error("multiplier result with no pending step");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC_WR) |-> $past(r_state == S_ACC_RD))
        else $error("accumulate write without prior read");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for multipole_expansion_accumulator_top: a directed table, then
// random clear/add/read and unused-code requests under several order and level settings, checked by a
// fixed-point expansion model kept here. Depends on mea_pkg and the RTL.
`default_nettype none

module tb;
    import mea_pkg::*;

    localparam logic [1:0] REQ_SPARE  = 2'd3;
    localparam logic [7:0] CFG_UNUSED = 8'd7;
    localparam int         TOP_ORDER  = 32;
    localparam longint     POS_LIM    = 64'sh7FFFFFFFFFFF;
    localparam int         DRAIN      = 2200;
    localparam int         STALL_MAX  = 20000;

    typedef struct {
        t_req        req;
        bit          chk;
        longint      m0_re;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    t_req        i_req = '0;
    logic        busy;
    logic        o_result_strobe;
    t_result     o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    longint      m_re [0:TOP_ORDER];
    longint      m_im [0:TOP_ORDER];
    bit          m_sat [0:TOP_ORDER];
    longint      recip [0:TOP_ORDER];
    logic [5:0]  cur_order;
    logic [4:0]  cur_level;
    t_result     coeff_due [$];
    t_row        rows [$];
    int          n_err = 0;
    int          idle_cycles = 0;

    multipole_expansion_accumulator_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_req          (i_req),
        .busy           (busy),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint clamp_mag(logic [127:0] mag, bit neg, inout bit s);
        logic [127:0] lim;
        lim = neg ? 128'h800000000000 : 128'h7FFFFFFFFFFF;
        if (mag > lim) begin
            mag = lim;
            s = 1'b1;
        end
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint sat_sum(longint v, inout bit s);
        if (v > POS_LIM) begin
            s = 1'b1;
            return POS_LIM;
        end
        if (v < -POS_LIM - 1) begin
            s = 1'b1;
            return -POS_LIM - 1;
        end
        return v;
    endfunction

    function automatic logic [127:0] mag_of(longint v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic longint mul_rnd(longint a, longint b, int sh, inout bit s);
        logic [127:0] p;
        p = (mag_of(a) * mag_of(b) + (128'd1 << (sh - 1))) >> sh;
        return clamp_mag(p, (a < 0) != (b < 0), s);
    endfunction

    task automatic cplx_mul(input longint ar, ai, br, bi, output longint rr, ri,
                            inout bit s);
        longint t1, t2, t3, t4;
        t1 = mul_rnd(ar, br, 24, s);
        t2 = mul_rnd(ai, bi, 24, s);
        t3 = mul_rnd(ar, bi, 24, s);
        t4 = mul_rnd(ai, br, 24, s);
        rr = sat_sum(t1 - t2, s);
        ri = sat_sum(t3 + t4, s);
    endtask

    function automatic int eff_order();
        if (cur_order < 1) return 1;
        if (cur_order > TOP_ORDER) return TOP_ORDER;
        return int'(cur_order);
    endfunction

    task automatic add_coeff(int j, longint dre, longint dim, bit chain);
        bit s;
        s = chain;
        m_re[j] = sat_sum(m_re[j] + dre, s);
        m_im[j] = sat_sum(m_im[j] + dim, s);
        if (s) m_sat[j] = 1'b1;
    endtask

    task automatic expand_particle(t_req r);
        int p, lv;
        bit chain, s;
        longint zr, zi, qq, mx, my, mr, mi, pr, pi, h, tr, ti, dr, di;
        p = eff_order();
        lv = int'(cur_level);
        chain = 1'b0;
        mx = 0;
        my = 0;
        pr = 0;
        pi = 0;
        zr = clamp_mag(((mag_of(longint'(r.offset_re)) << lv) + 32) >> 6,
                       r.offset_re < 0, chain);
        zi = clamp_mag(((mag_of(longint'(r.offset_im)) << lv) + 32) >> 6,
                       r.offset_im < 0, chain);
        qq = longint'(r.charge) * 256;
        if (r.has_dipole) begin
            mx = clamp_mag(mag_of(longint'(r.dipole_x)) << (lv + 8), r.dipole_x < 0, chain);
            my = clamp_mag(mag_of(longint'(r.dipole_y)) << (lv + 8), r.dipole_y < 0, chain);
        end
        add_coeff(0, -qq, 0, chain);
        mr = zr;
        mi = zi;
        for (int j = 1; j <= p; j++) begin
            s = 1'b0;
            if (j > 1) begin
                pr = mr;
                pi = mi;
                cplx_mul(pr, pi, zr, zi, mr, mi, chain);
            end
            h = mul_rnd(qq, recip[j], 31, s);
            tr = mul_rnd(h, mr, 24, s);
            ti = mul_rnd(h, mi, 24, s);
            add_coeff(j, -tr, -ti, chain || s);
            if (r.has_dipole) begin
                s = 1'b0;
                if (j == 1) begin
                    dr = mx;
                    di = my;
                end else begin
                    cplx_mul(mx, my, pr, pi, dr, di, s);
                end
                add_coeff(j, dr, di, chain || s);
            end
        end
    endtask

    task automatic predict(t_req r);
        t_result e;
        int p;
        case (r.req_type)
            REQ_CLEAR: begin
                for (int j = 0; j <= TOP_ORDER; j++) begin
                    m_re[j] = 0;
                    m_im[j] = 0;
                    m_sat[j] = 1'b0;
                end
            end
            REQ_ADD: expand_particle(r);
            REQ_READ: begin
                p = eff_order();
                for (int j = 0; j <= p; j++) begin
                    e.coeff_order = 6'(j);
                    e.coeff_re = m_re[j][47:0];
                    e.coeff_im = m_im[j][47:0];
                    e.last = (j == p);
                    e.saturated = m_sat[j];
                    coeff_due.push_back(e);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send(t_req r, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        predict(r);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (coeff_due.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ORDER) cur_order = data[5:0];
        else if (idx == CFG_LEVEL) cur_level = data[4:0];
    endtask

    function automatic t_req mk(logic [1:0] rt, logic [31:0] ore, oim, q, dx, dy, bit dip);
        t_req r;
        r.req_type = rt;
        r.offset_re = ore;
        r.offset_im = oim;
        r.charge = q;
        r.dipole_x = dx;
        r.dipole_y = dy;
        r.has_dipole = dip;
        return r;
    endfunction

    function automatic logic [31:0] small_val(int span);
        return $urandom_range(1, 0) ? 32'($urandom_range(span, 0))
                                    : -32'($urandom_range(span, 0));
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int k;
        r = t_req'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        k = $urandom_range(99, 0);
        r.req_type = k < 5 ? REQ_CLEAR : k < 25 ? REQ_READ : k < 29 ? REQ_SPARE : REQ_ADD;
        if ($urandom_range(1, 0)) begin
            r.offset_re = small_val(1 << 29);
            r.offset_im = small_val(1 << 29);
            r.charge = small_val(1 << 18);
            r.dipole_x = small_val(1 << 18);
            r.dipole_y = small_val(1 << 18);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            if (coeff_due.size() == 0) begin
                $display("%0t unexpected result order %0d", $time, o_result.coeff_order);
                n_err++;
            end else if (o_result !== coeff_due[0]) begin
                $display("%0t mismatch: expected ord %0d re %h im %h last %b sat %b",
                         $time, coeff_due[0].coeff_order, coeff_due[0].coeff_re,
                         coeff_due[0].coeff_im, coeff_due[0].last, coeff_due[0].saturated);
                $display("%0t           actual ord %0d re %h im %h last %b sat %b",
                         $time, o_result.coeff_order, o_result.coeff_re,
                         o_result.coeff_im, o_result.last, o_result.saturated);
                n_err++;
                void'(coeff_due.pop_front());
            end else begin
                void'(coeff_due.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_MAX) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        int orders [7];
        int levels [7];
        int counts [7];
        t_req r;
        orders = '{1, 3, 8, 0, 5, 63, 32};
        levels = '{0, 2, 7, 1, 20, 31, 0};
        counts = '{70, 70, 60, 60, 60, 50, 20};
        for (int j = 0; j <= TOP_ORDER; j++) begin
            m_re[j] = 0;
            m_im[j] = 0;
            m_sat[j] = 1'b0;
            recip[j] = j == 0 ? 0 : (((64'd1 << 32) / j) + 1) >> 1;
        end
        cur_order = ORDER_RESET;
        cur_level = LEVEL_RESET;

        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0), 1, 0});
        rows.push_back('{mk(REQ_ADD, 0, 0, 32'h10000, 0, 0, 0), 0, 0});
        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0), 1, -(64'sd1 << 24)});
        rows.push_back('{mk(REQ_SPARE, 32'h4000_0000, 1, 32'h10000, 1, 1, 1), 0, 0});
        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0), 1, -(64'sd1 << 24)});
        rows.push_back('{mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0), 1, 0});
        rows.push_back('{mk(REQ_ADD, 32'h2000_0000, 32'hE000_0000, 32'h20000,
                            32'h8000, 32'hFFFF_8000, 1), 0, 0});
        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(REQ_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 1), 0, 0});
        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(REQ_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, 0), 0, 0});
        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(REQ_ADD, 32'h1000_0000, 0, 0, 32'h10000, 32'h10000, 1), 0, 0});
        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0), 0, 0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send(rows[i].req, $urandom_range(8, 0));
            if (rows[i].chk) begin
                if (coeff_due[coeff_due.size() - eff_order() - 1].coeff_re
                        != rows[i].m0_re[47:0]) begin
                    $display("%0t mismatch: table M0 %h, model %h", $time,
                             rows[i].m0_re[47:0],
                             coeff_due[coeff_due.size() - eff_order() - 1].coeff_re);
                    n_err++;
                end
                coeff_due[coeff_due.size() - eff_order() - 1].coeff_re = rows[i].m0_re[47:0];
            end
        end

        for (int ph = 0; ph < 7; ph++) begin
            settle();
            cfg_write(CFG_ORDER, 32'(orders[ph]) | ($urandom & 32'hFFFF_FFC0));
            cfg_write(CFG_LEVEL, 32'(levels[ph]) | ($urandom & 32'hFFFF_FFE0));
            if (ph == 3) cfg_write(CFG_UNUSED, $urandom);
            @(posedge i_clk);
            send(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0), 0);
            for (int n = 0; n < counts[ph]; n++) begin
                r = rand_req();
                send(r, $urandom_range(8, 0));
            end
            send(mk(REQ_READ, 0, 0, 0, 0, 0, 0), $urandom_range(8, 0));
        end

        settle();
        if (n_err == 0 && coeff_due.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
src/mea_pkg.sv
src/mea_front.sv
src/mea_mul.sv
src/mea_back.sv
src/multipole_expansion_accumulator_top.sv
tb/sv/tb.sv
